// ----- design/kmp_pkg.sv -----
package kmp_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int PIDX_W      = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int BYTE_W      = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int CNT_W       = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_PAT_LEN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic              we;
		logic [PIDX_W-1:0] addr;
		logic [LEN_W-1:0]  data;
	} ft_wr_t;

endpackage

// ----- design/kmp_stream_if.sv -----
interface kmp_in_if;
	import kmp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              stream_start;

	modport source(output valid, output data_byte, output stream_start, input ready);
	modport sink(input valid, input data_byte, input stream_start, output ready);
endinterface

interface kmp_out_if;
	import kmp_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] progress;
	logic             match_found;
	logic [CNT_W-1:0] match_total;

	modport source(output valid, output progress, output match_found, output match_total,
		input ready);
	modport sink(input valid, input progress, input match_found, input match_total,
		output ready);
endinterface

// ----- design/kmp_cmp.sv -----
module kmp_cmp (
	input  logic [kmp_pkg::CFG_W-1:0]  pat_lo,
	input  logic [kmp_pkg::CFG_W-1:0]  pat_hi,
	input  logic [kmp_pkg::PIDX_W-1:0] idx,
	input  logic [kmp_pkg::BYTE_W-1:0] cur_byte,
	output logic [kmp_pkg::BYTE_W-1:0] sel_byte,
	output logic                       eq
);
	import kmp_pkg::*;

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;

	assign pat_bytes = {pat_hi, pat_lo};
	assign sel_byte  = pat_bytes[idx];
	assign eq        = (sel_byte == cur_byte);

endmodule

// ----- design/kmp_ftab.sv -----
module kmp_ftab (
	input  logic                       clk,
	input  kmp_pkg::ft_wr_t            wr,
	input  logic [kmp_pkg::PIDX_W-1:0] rd_idx,
	output logic [kmp_pkg::LEN_W-1:0]  rd_data
);
	import kmp_pkg::*;

	logic [LEN_W-1:0] tab_q [MAX_PATTERN];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			tab_q[wr.addr] <= wr.data;
		end
	end

	// Entry zero is never written by the builder and always reads as zero.
	assign rd_data = (rd_idx == '0) ? '0 : tab_q[rd_idx];

endmodule

// ----- design/kmp_stream_matcher.sv -----
// Channel   Modport  Payload                                   Request
// in_ch     sink     data_byte[7:0], stream_start              one stream byte
// out_ch    source   progress[4:0], match_found, match_total   one result per byte
// cfg_*     write    cfg_index[1:0], cfg_data[63:0]            pattern registers
//
// An accepted byte walks ST_M_WALK, following failure links on a mismatch, passes ST_M_FALL
// on a full match, and waits in ST_M_DONE until the output register is free; the single byte
// compare unit and the one table read port set this. No new byte is taken meanwhile.
// A register write rebuilds the failure table in ST_B_LOAD and ST_B_WALK; no byte
// is accepted meanwhile. Reset leaves a one-byte pattern of zero, ready at once.
// A stalled result stays in the output register while the next byte is taken.
module kmp_stream_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	kmp_in_if.sink                        in_ch,
	kmp_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [kmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kmp_pkg::CFG_W-1:0]     cfg_data
);
	import kmp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B_LOAD,
		ST_B_WALK,
		ST_M_WALK,
		ST_M_FALL,
		ST_M_DONE
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  pat_lo_q;
	logic [CFG_W-1:0]  pat_hi_q;
	logic [LEN_W-1:0]  pat_len_q;
	logic [LEN_W-1:0]  ptr_q;
	logic [LEN_W-1:0]  q_q;
	logic [BYTE_W-1:0] c_q;
	logic [LEN_W-1:0]  prog_q;
	logic [LEN_W-1:0]  shown_q;
	logic              found_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [LEN_W-1:0]  out_prog_q;
	logic              out_found_q;
	logic [CNT_W-1:0]  out_total_q;

	logic [LEN_W-1:0]  len_eff;
	logic [LEN_W-1:0]  len_m1;
	logic [LEN_W-1:0]  ptr_m1;
	logic [LEN_W-1:0]  ptr_adv;
	logic [PIDX_W-1:0] cmp_idx;
	logic [BYTE_W-1:0] sel_byte;
	logic              eq;
	logic              walk_mis;
	logic [PIDX_W-1:0] ft_rd_idx;
	logic [LEN_W-1:0]  ft_rd;
	ft_wr_t            ft_wr;
	logic              in_acc;
	logic              cfg_hit;
	logic              out_free;
	logic              out_load;

	// A length of zero acts as one, and one above the table size as the table size.
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = pat_len_q;
		end
	end

	assign len_m1    = len_eff - LEN_W'(1);
	assign ptr_m1    = ptr_q - LEN_W'(1);
	assign ptr_adv   = ptr_q + {{(LEN_W-1){1'b0}}, eq};
	assign cmp_idx   = (state_q == ST_B_LOAD) ? q_q[PIDX_W-1:0] : ptr_q[PIDX_W-1:0];
	assign walk_mis  = (ptr_q != '0) && !eq;
	assign ft_rd_idx = (state_q == ST_M_FALL) ? len_m1[PIDX_W-1:0] : ptr_m1[PIDX_W-1:0];
	assign in_acc    = in_ch.valid && in_ch.ready;
	assign cfg_hit   = cfg_we && (cfg_index == REG_PAT_LO || cfg_index == REG_PAT_HI ||
		cfg_index == REG_PAT_LEN);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = (state_q == ST_M_DONE) && out_free && !cfg_hit;

	assign ft_wr.we   = (state_q == ST_B_WALK) && !walk_mis;
	assign ft_wr.addr = q_q[PIDX_W-1:0];
	assign ft_wr.data = ptr_adv;

	kmp_cmp u_cmp (
		.pat_lo   (pat_lo_q),
		.pat_hi   (pat_hi_q),
		.idx      (cmp_idx),
		.cur_byte (c_q),
		.sel_byte (sel_byte),
		.eq       (eq)
	);

	kmp_ftab u_ftab (
		.clk     (clk),
		.wr      (ft_wr),
		.rd_idx  (ft_rd_idx),
		.rd_data (ft_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pat_lo_q    <= '0;
			pat_hi_q    <= '0;
			pat_len_q   <= LEN_W'(1);
			ptr_q       <= '0;
			q_q         <= '0;
			c_q         <= '0;
			prog_q      <= '0;
			shown_q     <= '0;
			found_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_prog_q  <= '0;
			out_found_q <= 1'b0;
			out_total_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				case (cfg_index)
					REG_PAT_LO:  pat_lo_q  <= cfg_data;
					REG_PAT_HI:  pat_hi_q  <= cfg_data;
					REG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
					default:     pat_len_q <= pat_len_q;
				endcase
				prog_q  <= '0;
				ptr_q   <= '0;
				q_q     <= LEN_W'(1);
				state_q <= ST_B_LOAD;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (in_acc) begin
							c_q <= in_ch.data_byte;
							if (in_ch.stream_start || prog_q >= len_eff) begin
								ptr_q <= '0;
							end else begin
								ptr_q <= prog_q;
							end
							state_q <= ST_M_WALK;
						end
					end
					ST_B_LOAD: begin
						if (q_q >= len_eff) begin
							state_q <= ST_IDLE;
						end else begin
							c_q     <= sel_byte;
							state_q <= ST_B_WALK;
						end
					end
					ST_B_WALK: begin
						if (walk_mis) begin
							ptr_q <= ft_rd;
						end else begin
							ptr_q   <= ptr_adv;
							q_q     <= q_q + LEN_W'(1);
							state_q <= ST_B_LOAD;
						end
					end
					ST_M_WALK: begin
						if (walk_mis) begin
							ptr_q <= ft_rd;
						end else begin
							shown_q <= ptr_adv;
							ptr_q   <= ptr_adv;
							if (ptr_adv == len_eff) begin
								found_q <= 1'b1;
								state_q <= ST_M_FALL;
							end else begin
								found_q <= 1'b0;
								state_q <= ST_M_DONE;
							end
						end
					end
					ST_M_FALL: begin
						// Fall back so that overlapping occurrences are still found.
						ptr_q   <= ft_rd;
						state_q <= ST_M_DONE;
					end
					ST_M_DONE: begin
						if (out_free) begin
							out_prog_q  <= shown_q;
							out_found_q <= found_q;
							out_total_q <= cnt_q + {{(CNT_W-1){1'b0}}, found_q};
							cnt_q       <= cnt_q + {{(CNT_W-1){1'b0}}, found_q};
							prog_q      <= ptr_q;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign in_ch.ready        = (state_q == ST_IDLE);
	assign out_ch.valid       = out_valid_q;
	assign out_ch.progress    = out_prog_q;
	assign out_ch.match_found = out_found_q;
	assign out_ch.match_total = out_total_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("byte accepted while the previous one is still in work");

	a_found_is_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.match_found) |-> (out_ch.progress == len_eff))
		else $error("match reported with progress short of the pattern length");

	a_prog_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.progress <= len_eff))
		else $error("progress beyond the pattern length");

	a_ft_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ft_wr.we |-> (ft_wr.data <= q_q))
		else $error("failure link longer than its own prefix");

endmodule
